FILE: src/lgtr_pkg.sv
// Package for the LCD glyph text renderer: font contents, command prefixes,
// result and memory request structs, sequencer states and the stretch helper.
// No dependencies.
package lgtr_pkg;

  localparam int FONT_CHARS = 97;
  localparam int FONT_COLS  = 5;
  localparam int FONT_DEPTH = FONT_CHARS * FONT_COLS;
  localparam int FONT_AW    = $clog2(FONT_DEPTH);
  localparam int GLYPH_W    = 7;

  localparam logic [7:0] FONT_FIRST  = 8'h20;
  localparam logic [7:0] FONT_LAST   = 8'h80;
  localparam logic [3:0] BANK_PREFIX = 4'b1000;
  localparam logic [2:0] LAST_GLYPH_COL = 3'd4;
  localparam logic [2:0] SPACER_COL  = 3'd5;
  localparam logic [6:0] LAST_CHAR   = 7'd96;
  localparam logic [6:0] NORMAL_STEP = 7'd6;
  localparam logic [6:0] DOUBLE_STEP = 7'd12;
  localparam logic [1:0] LAST_SUB    = 2'd3;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_EMIT,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic       move_cursor;
    logic [6:0] bank_command;
    logic [7:0] column_command;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [FONT_AW-1:0] waddr;
    logic [GLYPH_W-1:0] wdata;
    logic               re;
    logic [FONT_AW-1:0] raddr;
  } ram_req_t;

  // Five glyph columns of one character, column 0 in the top byte.
  function automatic logic [39:0] font_char(input logic [6:0] idx);
    logic [39:0] f;
    case (idx)
      7'd0:  f = 40'h0000000000;
      7'd1:  f = 40'h00005f0000;
      7'd2:  f = 40'h0007000700;
      7'd3:  f = 40'h147f147f14;
      7'd4:  f = 40'h242a7f2a12;
      7'd5:  f = 40'h2313086462;
      7'd6:  f = 40'h3649552250;
      7'd7:  f = 40'h0005030000;
      7'd8:  f = 40'h001c224100;
      7'd9:  f = 40'h0041221c00;
      7'd10: f = 40'h14083e0814;
      7'd11: f = 40'h08083e0808;
      7'd12: f = 40'h0050300000;
      7'd13: f = 40'h0808080808;
      7'd14: f = 40'h0060600000;
      7'd15: f = 40'h2010080402;
      7'd16: f = 40'h3e5149453e;
      7'd17: f = 40'h00427f4000;
      7'd18: f = 40'h4261514946;
      7'd19: f = 40'h2141454b31;
      7'd20: f = 40'h1814127f10;
      7'd21: f = 40'h2745454539;
      7'd22: f = 40'h3c4a494930;
      7'd23: f = 40'h0171090503;
      7'd24: f = 40'h3649494936;
      7'd25: f = 40'h064949291e;
      7'd26: f = 40'h0036360000;
      7'd27: f = 40'h0056360000;
      7'd28: f = 40'h0814224100;
      7'd29: f = 40'h1414141414;
      7'd30: f = 40'h0041221408;
      7'd31: f = 40'h0201510906;
      7'd32: f = 40'h324979413e;
      7'd33: f = 40'h7e1111117e;
      7'd34: f = 40'h7f49494936;
      7'd35: f = 40'h3e41414122;
      7'd36: f = 40'h7f4141221c;
      7'd37: f = 40'h7f49494941;
      7'd38: f = 40'h7f09090901;
      7'd39: f = 40'h3e4149497a;
      7'd40: f = 40'h7f0808087f;
      7'd41: f = 40'h00417f4100;
      7'd42: f = 40'h2040413f01;
      7'd43: f = 40'h7f08142241;
      7'd44: f = 40'h7f40404040;
      7'd45: f = 40'h7f020c027f;
      7'd46: f = 40'h7f0408107f;
      7'd47: f = 40'h3e4141413e;
      7'd48: f = 40'h7f09090906;
      7'd49: f = 40'h3e4151215e;
      7'd50: f = 40'h7f09192946;
      7'd51: f = 40'h4649494931;
      7'd52: f = 40'h01017f0101;
      7'd53: f = 40'h3f4040403f;
      7'd54: f = 40'h1f2040201f;
      7'd55: f = 40'h3f4038403f;
      7'd56: f = 40'h6314081463;
      7'd57: f = 40'h0708700807;
      7'd58: f = 40'h6151494543;
      7'd59: f = 40'h007f414100;
      7'd60: f = 40'h0204081020;
      7'd61: f = 40'h0041417f00;
      7'd62: f = 40'h0402010204;
      7'd63: f = 40'h4040404040;
      7'd64: f = 40'h0001020400;
      7'd65: f = 40'h2054545478;
      7'd66: f = 40'h7f48444438;
      7'd67: f = 40'h3844444420;
      7'd68: f = 40'h384444487f;
      7'd69: f = 40'h3854545418;
      7'd70: f = 40'h087e090102;
      7'd71: f = 40'h0c5252523e;
      7'd72: f = 40'h7f08040478;
      7'd73: f = 40'h00447d4000;
      7'd74: f = 40'h2040443d00;
      7'd75: f = 40'h7f10284400;
      7'd76: f = 40'h00417f4000;
      7'd77: f = 40'h7c04180478;
      7'd78: f = 40'h7c08040478;
      7'd79: f = 40'h3844444438;
      7'd80: f = 40'h7c14141408;
      7'd81: f = 40'h081414187c;
      7'd82: f = 40'h7c08040408;
      7'd83: f = 40'h4854545420;
      7'd84: f = 40'h043f444020;
      7'd85: f = 40'h3c4040207c;
      7'd86: f = 40'h1c2040201c;
      7'd87: f = 40'h3c4030403c;
      7'd88: f = 40'h4428102844;
      7'd89: f = 40'h0c5050503c;
      7'd90: f = 40'h4464544c44;
      7'd91: f = 40'h0008364100;
      7'd92: f = 40'h00007f0000;
      7'd93: f = 40'h0041360800;
      7'd94: f = 40'h1008081008;
      7'd95: f = 40'h7846414678;
      7'd96: f = 40'h0006090906;
      default: f = 40'h0000000000;
    endcase
    return f;
  endfunction

  function automatic logic [GLYPH_W-1:0] font_col(input logic [39:0] f,
                                                   input logic [2:0] c);
    logic [GLYPH_W-1:0] v;
    case (c)
      3'd0:    v = f[38:32];
      3'd1:    v = f[30:24];
      3'd2:    v = f[22:16];
      3'd3:    v = f[14:8];
      3'd4:    v = f[6:0];
      default: v = '0;
    endcase
    return v;
  endfunction

  // Each of the seven bits becomes two adjacent bits.
  function automatic logic [13:0] stretch7(input logic [6:0] v);
    logic [13:0] b;
    for (int i = 0; i < 7; i++) begin
      b[2*i]   = v[i];
      b[2*i+1] = v[i];
    end
    return b;
  endfunction

endpackage

FILE: src/lgtr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lgtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/lgtr_ctrl.sv
// Sequencer of the glyph renderer: font memory load after reset, column fetch
// and the expansion of each column into display writes. Uses lgtr_pkg.
module lgtr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_stall,
  input  logic [7:0]              char_code,
  input  logic                    new_string,
  input  logic [6:0]              start_column,
  input  logic [2:0]              bank,
  input  logic                    double_size,
  input  logic                    invert,
  output lgtr_pkg::ram_req_t      ram_req,
  input  logic [lgtr_pkg::GLYPH_W-1:0] ram_rdata,
  output logic                    res_valid,
  output lgtr_pkg::result_t       res,
  input  logic                    res_ready
);
  import lgtr_pkg::*;

  state_t state, state_next;

  logic [6:0]         fill_char;
  logic [2:0]         fill_col;
  logic [FONT_AW-1:0] fill_addr;

  logic [FONT_AW-1:0] base;
  logic               in_font;
  logic [2:0]         bk;
  logic               dbl;
  logic               inv;
  logic [6:0]         col;
  logic [6:0]         pos;
  logic [2:0]         col_idx;
  logic [1:0]         sub;
  logic [7:0]         glyph;
  logic [6:0]         next_column;

  logic               accept;
  logic               col_done;
  logic [6:0]         col_in;
  logic [7:0]         code_off;
  logic [GLYPH_W-1:0] glyph_raw;
  logic [13:0]        stretched;

  assign accept   = (state == ST_IDLE) && char_valid;
  assign col_done = dbl ? (sub == LAST_SUB) : 1'b1;
  assign col_in   = new_string ? start_column : next_column;
  assign code_off = char_code - FONT_FIRST;
  assign glyph_raw = (in_font && (col_idx != SPACER_COL)) ? ram_rdata : '0;
  assign stretched = stretch7(glyph[6:0]);

  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (fill_addr == FONT_AW'(FONT_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (char_valid) state_next = ST_READ;
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_ready && col_done) begin
          if (col_idx != SPACER_COL) state_next = ST_READ;
          else if (dbl)              state_next = ST_TAIL;
          else                       state_next = ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_comb begin
    char_stall    = (state != ST_IDLE);
    ram_req.we    = (state == ST_FILL);
    ram_req.waddr = fill_addr;
    ram_req.wdata = font_col(font_char(fill_char), fill_col);
    ram_req.re    = (state == ST_READ);
    ram_req.raddr = base + FONT_AW'(col_idx);
    res_valid     = 1'b0;
    res.move_cursor    = 1'b0;
    res.bank_command   = {BANK_PREFIX, bk};
    res.column_command = {1'b1, col};
    res.data_byte      = 8'h00;
    res.last           = 1'b0;
    case (state)
      ST_EMIT: begin
        res_valid = 1'b1;
        if (dbl) begin
          res.move_cursor    = 1'b1;
          res.bank_command   = {BANK_PREFIX, bk + {2'b00, sub[0]}};
          res.column_command = {1'b1, pos + {6'd0, sub[1]}};
          res.data_byte      = sub[0] ? {2'b00, stretched[13:8]} : stretched[7:0];
        end else begin
          res.move_cursor = (col_idx == 3'd0);
          res.data_byte   = glyph;
          res.last        = (col_idx == SPACER_COL);
        end
      end
      ST_TAIL: begin
        res_valid = 1'b1;
        res.last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      fill_char   <= '0;
      fill_col    <= '0;
      fill_addr   <= '0;
      next_column <= '0;
      col_idx     <= '0;
      sub         <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FILL) begin
        fill_addr <= fill_addr + 1'b1;
        if (fill_col == LAST_GLYPH_COL) begin
          fill_col  <= '0;
          fill_char <= (fill_char == LAST_CHAR) ? fill_char : fill_char + 1'b1;
        end else begin
          fill_col <= fill_col + 1'b1;
        end
      end
      if (accept) begin
        col_idx     <= '0;
        sub         <= '0;
        next_column <= col_in + (double_size ? DOUBLE_STEP : NORMAL_STEP);
      end
      if (state == ST_EMIT && res_ready) begin
        if (col_done) begin
          sub     <= '0;
          col_idx <= col_idx + 1'b1;
        end else begin
          sub <= sub + 1'b1;
        end
      end
    end
  end

  // Per-character payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_font <= (char_code >= FONT_FIRST) && (char_code <= FONT_LAST);
      base    <= {code_off[6:0], 2'b00} + {2'b00, code_off[6:0]};
      bk      <= bank;
      dbl     <= double_size;
      inv     <= invert;
      col     <= col_in;
      pos     <= col_in;
    end
    if (state == ST_LOAD) begin
      glyph <= inv ? ~{1'b0, glyph_raw} : {1'b0, glyph_raw};
    end
    if (state == ST_EMIT && res_ready && col_done) begin
      pos <= pos + 7'd2;
    end
  end

endmodule

FILE: src/lcd_glyph_text_renderer.sv
// Top level of the LCD glyph text renderer: font memory, sequencer and the
// output register. Uses lgtr_pkg, lgtr_ram and lgtr_ctrl.
//
//   channel | signals                                          | accepted when
//   char    | char_valid, char_stall, char_code, new_string,   | valid & !stall
//           | start_column, bank, double_size, invert          |
//   write   | write_valid, write_stall, move_cursor,           | valid & !stall
//           | bank_command, column_command, data_byte, last    |
//
// A character is accepted in the idle state and drawn as six columns, each
// passing through the read, load and emit states; a column is one write in
// normal size and four in double size, which adds a trailing write. Each
// column waits on one read of the font memory. After reset the font memory
// is loaded with char_stall high. A stalled write holds the sequencer in place.
module lcd_glyph_text_renderer (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_code,
  input  logic       new_string,
  input  logic [6:0] start_column,
  input  logic [2:0] bank,
  input  logic       double_size,
  input  logic       invert,
  output logic       write_valid,
  input  logic       write_stall,
  output logic       move_cursor,
  output logic [6:0] bank_command,
  output logic [7:0] column_command,
  output logic [7:0] data_byte,
  output logic       last
);
  import lgtr_pkg::*;

  ram_req_t           ram_req;
  logic [GLYPH_W-1:0] ram_rdata;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_reg;

  lgtr_ram #(
    .WIDTH(GLYPH_W),
    .DEPTH(FONT_DEPTH)
  ) u_font (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  lgtr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .new_string  (new_string),
    .start_column(start_column),
    .bank        (bank),
    .double_size (double_size),
    .invert      (invert),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  assign res_ready = !write_valid || !write_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (res_ready) begin
      write_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign move_cursor    = out_reg.move_cursor;
  assign bank_command   = out_reg.bank_command;
  assign column_command = out_reg.column_command;
  assign data_byte      = out_reg.data_byte;
  assign last           = out_reg.last;

endmodule

FILE: src/lgtr_checker.sv
// Port-level checks for the LCD glyph text renderer, bound to the top level.
// Depends on lcd_glyph_text_renderer only through its ports.
module lgtr_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic       write_valid,
  input logic       write_stall,
  input logic       move_cursor,
  input logic [6:0] bank_command,
  input logic [7:0] column_command,
  input logic [7:0] data_byte,
  input logic       last
);

  // The font load follows every reset, so no character is taken right after it.
  a_stall_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> char_stall)
    else $error("character taken right after reset");

  // One character is worked on at a time.
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall) |=> char_stall)
    else $error("second character taken while one is in work");

  a_write_hold: assert property (@(posedge clk) disable iff (rst)
    (write_valid && write_stall) |=>
      (write_valid && $stable(move_cursor) && $stable(bank_command) &&
       $stable(column_command) && $stable(data_byte) && $stable(last)))
    else $error("stalled write transaction changed");

  // The final write of a character never carries cursor commands.
  a_last_unpositioned: assert property (@(posedge clk) disable iff (rst)
    write_valid |-> !(move_cursor && last))
    else $error("final write carries cursor commands");

endmodule

bind lcd_glyph_text_renderer lgtr_checker u_lgtr_checker (.*);

FILE: dv/lcd_glyph_text_renderer_tb.sv
// Self-checking testbench for lcd_glyph_text_renderer: drives characters, predicts
// every LCD write from its own font table and compares the write stream.
// Depends on lgtr_pkg (result_t, font code limits) and the renderer RTL.
module lcd_glyph_text_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgtr_pkg::*;

  localparam int         IDLE_LIMIT   = 3000;
  localparam int         SETTLE_WAIT  = 60;
  localparam int         MAX_SHOWN    = 10;
  localparam logic [3:0] BANK_CMD_HI  = 4'b1000;
  localparam logic       COL_CMD_HI   = 1'b1;
  localparam logic [6:0] NORMAL_ADV   = 7'd6;
  localparam logic [6:0] DOUBLE_ADV   = 7'd12;
  localparam logic [7:0] SPACER_INV   = 8'hff;

  // Five 7-bit columns per character, codes 0x20 through 0x80.
  localparam logic [6:0] GLYPH_TABLE [485] = '{
    'h00,'h00,'h00,'h00,'h00, 'h00,'h00,'h5f,'h00,'h00, 'h00,'h07,'h00,'h07,'h00,
    'h14,'h7f,'h14,'h7f,'h14, 'h24,'h2a,'h7f,'h2a,'h12, 'h23,'h13,'h08,'h64,'h62,
    'h36,'h49,'h55,'h22,'h50, 'h00,'h05,'h03,'h00,'h00, 'h00,'h1c,'h22,'h41,'h00,
    'h00,'h41,'h22,'h1c,'h00, 'h14,'h08,'h3e,'h08,'h14, 'h08,'h08,'h3e,'h08,'h08,
    'h00,'h50,'h30,'h00,'h00, 'h08,'h08,'h08,'h08,'h08, 'h00,'h60,'h60,'h00,'h00,
    'h20,'h10,'h08,'h04,'h02, 'h3e,'h51,'h49,'h45,'h3e, 'h00,'h42,'h7f,'h40,'h00,
    'h42,'h61,'h51,'h49,'h46, 'h21,'h41,'h45,'h4b,'h31, 'h18,'h14,'h12,'h7f,'h10,
    'h27,'h45,'h45,'h45,'h39, 'h3c,'h4a,'h49,'h49,'h30, 'h01,'h71,'h09,'h05,'h03,
    'h36,'h49,'h49,'h49,'h36, 'h06,'h49,'h49,'h29,'h1e, 'h00,'h36,'h36,'h00,'h00,
    'h00,'h56,'h36,'h00,'h00, 'h08,'h14,'h22,'h41,'h00, 'h14,'h14,'h14,'h14,'h14,
    'h00,'h41,'h22,'h14,'h08, 'h02,'h01,'h51,'h09,'h06, 'h32,'h49,'h79,'h41,'h3e,
    'h7e,'h11,'h11,'h11,'h7e, 'h7f,'h49,'h49,'h49,'h36, 'h3e,'h41,'h41,'h41,'h22,
    'h7f,'h41,'h41,'h22,'h1c, 'h7f,'h49,'h49,'h49,'h41, 'h7f,'h09,'h09,'h09,'h01,
    'h3e,'h41,'h49,'h49,'h7a, 'h7f,'h08,'h08,'h08,'h7f, 'h00,'h41,'h7f,'h41,'h00,
    'h20,'h40,'h41,'h3f,'h01, 'h7f,'h08,'h14,'h22,'h41, 'h7f,'h40,'h40,'h40,'h40,
    'h7f,'h02,'h0c,'h02,'h7f, 'h7f,'h04,'h08,'h10,'h7f, 'h3e,'h41,'h41,'h41,'h3e,
    'h7f,'h09,'h09,'h09,'h06, 'h3e,'h41,'h51,'h21,'h5e, 'h7f,'h09,'h19,'h29,'h46,
    'h46,'h49,'h49,'h49,'h31, 'h01,'h01,'h7f,'h01,'h01, 'h3f,'h40,'h40,'h40,'h3f,
    'h1f,'h20,'h40,'h20,'h1f, 'h3f,'h40,'h38,'h40,'h3f, 'h63,'h14,'h08,'h14,'h63,
    'h07,'h08,'h70,'h08,'h07, 'h61,'h51,'h49,'h45,'h43, 'h00,'h7f,'h41,'h41,'h00,
    'h02,'h04,'h08,'h10,'h20, 'h00,'h41,'h41,'h7f,'h00, 'h04,'h02,'h01,'h02,'h04,
    'h40,'h40,'h40,'h40,'h40, 'h00,'h01,'h02,'h04,'h00, 'h20,'h54,'h54,'h54,'h78,
    'h7f,'h48,'h44,'h44,'h38, 'h38,'h44,'h44,'h44,'h20, 'h38,'h44,'h44,'h48,'h7f,
    'h38,'h54,'h54,'h54,'h18, 'h08,'h7e,'h09,'h01,'h02, 'h0c,'h52,'h52,'h52,'h3e,
    'h7f,'h08,'h04,'h04,'h78, 'h00,'h44,'h7d,'h40,'h00, 'h20,'h40,'h44,'h3d,'h00,
    'h7f,'h10,'h28,'h44,'h00, 'h00,'h41,'h7f,'h40,'h00, 'h7c,'h04,'h18,'h04,'h78,
    'h7c,'h08,'h04,'h04,'h78, 'h38,'h44,'h44,'h44,'h38, 'h7c,'h14,'h14,'h14,'h08,
    'h08,'h14,'h14,'h18,'h7c, 'h7c,'h08,'h04,'h04,'h08, 'h48,'h54,'h54,'h54,'h20,
    'h04,'h3f,'h44,'h40,'h20, 'h3c,'h40,'h40,'h20,'h7c, 'h1c,'h20,'h40,'h20,'h1c,
    'h3c,'h40,'h30,'h40,'h3c, 'h44,'h28,'h10,'h28,'h44, 'h0c,'h50,'h50,'h50,'h3c,
    'h44,'h64,'h54,'h4c,'h44, 'h00,'h08,'h36,'h41,'h00, 'h00,'h00,'h7f,'h00,'h00,
    'h00,'h41,'h36,'h08,'h00, 'h10,'h08,'h08,'h10,'h08, 'h78,'h46,'h41,'h46,'h78,
    'h00,'h06,'h09,'h09,'h06
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] char_code = '0;
  logic       new_string = 1'b0;
  logic [6:0] start_column = '0;
  logic [2:0] bank = '0;
  logic       double_size = 1'b0;
  logic       invert = 1'b0;
  logic       write_valid;
  logic       write_stall = 1'b0;
  logic       move_cursor;
  logic [6:0] bank_command;
  logic [7:0] column_command;
  logic [7:0] data_byte;
  logic       last;

  result_t    lcd_writes_q[$];
  logic [6:0] cursor_col = '0;
  int         fail_count = 0;
  int         shown_count = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         send_gaps = 1'b0;
  bit         recv_stalls = 1'b0;

  lcd_glyph_text_renderer u_top (.*);

  always #5 clk = ~clk;

  // Each glyph bit covers two pixel rows in double size.
  function automatic logic [13:0] double_rows(input logic [6:0] v);
    logic [13:0] b;
    for (int i = 0; i < 7; i++) begin
      b[2*i]   = v[i];
      b[2*i+1] = v[i];
    end
    return b;
  endfunction

  function automatic result_t lcd_write(input logic mv, input logic [2:0] bk,
                                        input logic [6:0] col, input logic [7:0] data,
                                        input logic lst);
    result_t r;
    r.move_cursor    = mv;
    r.bank_command   = {BANK_CMD_HI, bk};
    r.column_command = {COL_CMD_HI, col};
    r.data_byte      = data;
    r.last           = lst;
    return r;
  endfunction

  // Queues the writes that draw one character and moves the cursor column on.
  function automatic void predict_char_writes(input logic [7:0] code, input logic ns,
                                              input logic [6:0] sc, input logic [2:0] bk,
                                              input logic dbl, input logic inv);
    logic [6:0]  col;
    logic [6:0]  c0;
    logic [7:0]  cols [6];
    logic [6:0]  g;
    logic [13:0] rows;
    col = ns ? sc : cursor_col;
    for (int i = 0; i < 5; i++) begin
      g = '0;
      if (code >= FONT_FIRST && code <= FONT_LAST)
        g = GLYPH_TABLE[(int'(code) - int'(FONT_FIRST)) * 5 + i];
      cols[i] = inv ? ~{1'b0, g} : {1'b0, g};
    end
    cols[5] = inv ? SPACER_INV : 8'h00;
    if (!dbl) begin
      for (int i = 0; i < 6; i++)
        lcd_writes_q.push_back(lcd_write(i == 0, bk, col, cols[i], i == 5));
      cursor_col = col + NORMAL_ADV;
    end else begin
      for (int i = 0; i < 6; i++) begin
        rows = double_rows(cols[i][6:0]);
        c0   = col + 7'(2 * i);
        lcd_writes_q.push_back(lcd_write(1'b1, bk, c0, rows[7:0], 1'b0));
        lcd_writes_q.push_back(lcd_write(1'b1, bk + 3'd1, c0, {2'b00, rows[13:8]}, 1'b0));
        lcd_writes_q.push_back(lcd_write(1'b1, bk, c0 + 7'd1, rows[7:0], 1'b0));
        lcd_writes_q.push_back(lcd_write(1'b1, bk + 3'd1, c0 + 7'd1,
                                         {2'b00, rows[13:8]}, 1'b0));
      end
      lcd_writes_q.push_back(lcd_write(1'b0, bk, col, 8'h00, 1'b1));
      cursor_col = col + DOUBLE_ADV;
    end
  endfunction

  // Offers one character and returns at the edge where the transaction completes.
  task automatic send_char(input logic [7:0] code, input logic ns, input logic [6:0] sc,
                           input logic [2:0] bk, input logic dbl, input logic inv);
    int gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid   <= 1'b1;
    char_code    <= code;
    new_string   <= ns;
    start_column <= sc;
    bank         <= bk;
    double_size  <= dbl;
    invert       <= inv;
    @(posedge clk);
    while (char_stall !== 1'b0) @(posedge clk);
    predict_char_writes(code, ns, sc, bk, dbl, inv);
  endtask

  task automatic wait_writes_drained();
    char_valid <= 1'b0;
    while (lcd_writes_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(int'(FONT_FIRST), int'(FONT_LAST)));
  endfunction

  task automatic test_normal_glyphs();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    send_char(8'h20, 1'b1, 7'd0,   3'd0, 1'b0, 1'b0);
    send_char(8'h41, 1'b0, 7'd99,  3'd0, 1'b0, 1'b0);
    send_char(8'h80, 1'b0, 7'd0,   3'd7, 1'b0, 1'b1);
    send_char(8'h7f, 1'b0, 7'd127, 3'd5, 1'b0, 1'b0);
    // Codes outside the font draw blank columns, or filled ones when inverted.
    send_char(8'h00, 1'b1, 7'd64,  3'd2, 1'b0, 1'b0);
    send_char(8'h1f, 1'b0, 7'd0,   3'd2, 1'b0, 1'b1);
    send_char(8'h81, 1'b0, 7'd0,   3'd1, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 7'd0,   3'd6, 1'b0, 1'b1);
    // The column after 127 wraps to 5.
    send_char(8'h57, 1'b1, 7'd127, 3'd4, 1'b0, 1'b0);
    send_char(8'h5a, 1'b0, 7'd0,   3'd4, 1'b0, 1'b1);
  endtask

  task automatic test_double_glyphs();
    send_char(8'h40, 1'b1, 7'd0,   3'd7, 1'b1, 1'b0);
    send_char(8'h58, 1'b0, 7'd33,  3'd3, 1'b1, 1'b1);
    send_char(8'h20, 1'b1, 7'd120, 3'd0, 1'b1, 1'b1);
    send_char(8'h80, 1'b0, 7'd0,   3'd6, 1'b1, 1'b0);
    send_char(8'hff, 1'b1, 7'd127, 3'd7, 1'b1, 1'b1);
    send_char(8'h10, 1'b0, 7'd1,   3'd2, 1'b1, 1'b0);
    send_char(8'h61, 1'b0, 7'd0,   3'd1, 1'b0, 1'b0);
    wait_writes_drained();
  endtask

  // Strings: a first character that sets the column, then followers that ride on
  // the cursor column. A few characters break the pattern on purpose.
  task automatic test_string_stream(input int n_chars);
    int         sent;
    int         len;
    logic [2:0] bk;
    logic       dbl;
    logic       inv;
    logic       ns;
    sent = 0;
    while (sent < n_chars) begin
      len         = $urandom_range(1, 12);
      bk          = 3'($urandom_range(0, 7));
      dbl         = ($urandom_range(0, 9) < 3);
      inv         = ($urandom_range(0, 3) == 0);
      send_gaps   = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < len && sent < n_chars; i++) begin
        ns = (i == 0);
        if ($urandom_range(0, 19) == 0) begin
          ns  = 1'($urandom_range(0, 1));
          bk  = 3'($urandom_range(0, 7));
          dbl = 1'($urandom_range(0, 1));
          inv = 1'($urandom_range(0, 1));
        end
        send_char(pick_code(), ns, 7'($urandom_range(0, 127)), bk, dbl, inv);
        sent++;
      end
      if (sent >= n_chars / 2 && sent - len < n_chars / 2)
        wait_writes_drained();
    end
  endtask

  task automatic test_back_to_back(input int n_chars);
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    for (int i = 0; i < n_chars; i++)
      send_char(pick_code(), ($urandom_range(0, 7) == 0), 7'($urandom_range(0, 127)),
                3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0),
                1'($urandom_range(0, 1)));
  endtask

  // Write-side stall bursts and the result comparison.
  always @(posedge clk) begin
    result_t act;
    result_t exp_w;
    if (!rst && write_valid === 1'b1 && write_stall === 1'b0) begin
      act = '{move_cursor, bank_command, column_command, data_byte, last};
      if (lcd_writes_q.size() == 0) begin
        fail_count++;
        if (shown_count < MAX_SHOWN) begin
          shown_count++;
          $display("%0t: write with nothing pending: %p", $realtime, act);
        end
      end else begin
        exp_w = lcd_writes_q.pop_front();
        if (act.move_cursor !== exp_w.move_cursor ||
            act.bank_command !== exp_w.bank_command ||
            act.column_command !== exp_w.column_command ||
            act.data_byte !== exp_w.data_byte || act.last !== exp_w.last) begin
          fail_count++;
          if (shown_count < MAX_SHOWN) begin
            shown_count++;
            $display("%0t: write mismatch mv %b/%b bank %h/%h col %h/%h data %h/%h last %b/%b",
                     $realtime, exp_w.move_cursor, act.move_cursor,
                     exp_w.bank_command, act.bank_command,
                     exp_w.column_command, act.column_command,
                     exp_w.data_byte, act.data_byte, exp_w.last, act.last);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      write_stall <= 1'b1;
    end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      write_stall <= 1'b1;
    end else begin
      write_stall <= 1'b0;
    end
  end

  // Ends the run if neither channel completes a transaction for too long.
  always @(posedge clk) begin
    if ((char_valid && char_stall === 1'b0) || (write_valid === 1'b1 && !write_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_normal_glyphs();
    test_double_glyphs();
    test_string_stream(250);
    test_back_to_back(40);
    wait_writes_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (fail_count == 0 && lcd_writes_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
